// File: hdl/csmb_pkg.sv
package csmb_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned REACH_W    = 4;
  localparam int unsigned DIM_W      = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH        = 2'd2;

  localparam logic [FW_W-1:0]    FW_RESET    = 11'd1024;
  localparam logic [FH_W-1:0]    FH_RESET    = 13'd1024;
  localparam logic [REACH_W-1:0] REACH_RESET = 4'd4;

  // floor(x / 5) == (x * RECIP5) >> DIV_SHIFT for every x below 2**SUM_W
  localparam int unsigned SUM_W     = 19;
  localparam int unsigned DIV_SHIFT = 21;
  localparam int unsigned PROD_W    = 2 * SUM_W;
  localparam logic [SUM_W-1:0] RECIP5 = 19'd419431;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QLW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] blurred;
    logic             frame_done;
  } out_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] lft;
    logic [PIX_W-1:0] rgt;
    logic             done;
    logic             kzero;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// File: hdl/csmb_ram.sv
module csmb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hdl/csmb_queue.sv
module csmb_queue import csmb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  push_t          push_i,
  input  logic           pop_i,
  output q_head_t        head_o,
  output logic [QLW-1:0] level_o
);

  q_entry_t       ent_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QLW-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    level_d  = level_q + QLW'(push_i.valid) - QLW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid = (level_q != '0);
  assign head_o.entry = ent_q[rd_ptr_q];
  assign level_o      = level_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (level_q < QLW'(QDEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (level_q != '0))
    else $error("queue pop while empty");

endmodule

// File: hdl/csmb_front.sv
module csmb_front import csmb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_REACH  = 8,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  input  logic [QLW-1:0]        q_level_i,
  output push_t                 push_o
);

  localparam int unsigned STORE_ROWS = 2 * MAX_REACH;
  localparam int unsigned SLW        = $clog2(STORE_ROWS);
  localparam int unsigned CAW        = $clog2(MAX_WIDTH);
  localparam int unsigned KW         = $clog2(MAX_REACH + 1);
  localparam int unsigned AW         = SLW + CAW;
  localparam int unsigned RAM_DEPTH  = STORE_ROWS * (2 ** CAW);
  localparam logic [SLW:0]   ROWS_X  = (SLW + 1)'(STORE_ROWS);
  localparam logic [SLW-1:0] SLOT_LAST = SLW'(STORE_ROWS - 1);

  logic [FW_W-1:0]    fw_q;
  logic [FH_W-1:0]    fh_q;
  logic [REACH_W-1:0] reach_q;

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [SLW-1:0]   slot_q, slot_d;

  logic             f1_valid_q;
  logic [ROW_W-1:0] f1_row_q;
  logic [COL_W-1:0] f1_col_q;
  logic [PIX_W-1:0] f1_pix_q;
  logic             f1_done_q;
  logic             f1_kzero_q;

  logic [FW_W-1:0]       w_eff;
  logic [FH_W-1:0]       h_eff;
  logic [KW-1:0]         k_eff;
  logic                  acc;
  logic [ROW_W-1:0]      r_cur;
  logic [COL_W-1:0]      c_cur;
  logic [SLW-1:0]        slot_cur;
  logic [DIM_W-1:0]      r_x, c_x, k_x, w_x, h_x;
  logic                  interior;
  logic                  done;
  logic [ROW_W-1:0]      cr;
  logic [SLW:0]          sl_x, ks_x, k2s_x, ctr_sl, up_sl;
  logic [DIM_W-1:0]      lft_c, rgt_c;
  logic [AW-1:0]         waddr, up_addr, ctr_addr, lft_addr, rgt_addr;
  logic [PIXEL_BITS-1:0] pix;
  logic [FW_W:0]         c_next;
  logic [FH_W:0]         r_next;
  logic [QLW:0]          credit;
  logic [PIXEL_BITS-1:0] rd_up, rd_ctr, rd_lft, rd_rgt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= FW_RESET;
      fh_q    <= FH_RESET;
      reach_q <= REACH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  fw_q    <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q    <= cfg_data_i[FH_W-1:0];
        CFG_REACH:        reach_q <= cfg_data_i[REACH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) begin
      w_eff = FW_W'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    if (fh_q == '0) begin
      h_eff = FH_W'(1);
    end else if (32'(fh_q) > MAX_HEIGHT) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
    k_eff = (32'(reach_q) > MAX_REACH) ? KW'(MAX_REACH) : KW'(reach_q);
  end

  assign credit     = (QLW + 1)'(q_level_i) + (QLW + 1)'(f1_valid_q);
  assign in_stall_o = (credit >= (QLW + 1)'(QDEPTH));
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    r_cur    = in_word_i.frame_start ? '0 : row_q;
    c_cur    = in_word_i.frame_start ? '0 : col_q;
    slot_cur = in_word_i.frame_start ? '0 : slot_q;
    pix      = in_word_i.pixel[PIXEL_BITS-1:0];

    r_x = DIM_W'(r_cur);
    c_x = DIM_W'(c_cur);
    k_x = DIM_W'(k_eff);
    w_x = DIM_W'(w_eff);
    h_x = DIM_W'(h_eff);

    interior = (r_x >= (k_x << 1)) && (r_x < h_x) && (c_x >= k_x) && ((c_x + k_x) < w_x);
    done     = (r_x == h_x - 1'b1) && ((c_x + k_x + 1'b1) == w_x);
    cr       = r_cur - ROW_W'(k_eff);

    // row slots of the center and upper neighbor, modulo the store depth
    sl_x   = (SLW + 1)'(slot_cur);
    ks_x   = (SLW + 1)'(k_eff);
    k2s_x  = ks_x << 1;
    ctr_sl = (sl_x >= ks_x) ? sl_x - ks_x : sl_x + ROWS_X - ks_x;
    up_sl  = (sl_x >= k2s_x) ? sl_x - k2s_x : sl_x + ROWS_X - k2s_x;

    lft_c = c_x - k_x;
    rgt_c = c_x + k_x;

    waddr    = {slot_cur, CAW'(c_cur)};
    ctr_addr = {ctr_sl[SLW-1:0], CAW'(c_cur)};
    up_addr  = {up_sl[SLW-1:0], CAW'(c_cur)};
    lft_addr = {ctr_sl[SLW-1:0], lft_c[CAW-1:0]};
    rgt_addr = {ctr_sl[SLW-1:0], rgt_c[CAW-1:0]};
  end

  always_comb begin
    c_next = (FW_W + 1)'(c_cur) + 1'b1;
    r_next = (FH_W + 1)'(r_cur) + 1'b1;
    row_d  = r_cur;
    col_d  = c_next[COL_W-1:0];
    slot_d = slot_cur;
    if (c_next >= (FW_W + 1)'(w_eff)) begin
      col_d = '0;
      if (r_next >= (FH_W + 1)'(h_eff)) begin
        row_d = '0;
      end else begin
        row_d = r_next[ROW_W-1:0];
      end
      if (row_d == '0) begin
        slot_d = '0;
      end else if (slot_cur == SLOT_LAST) begin
        slot_d = '0;
      end else begin
        slot_d = slot_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      slot_q     <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= acc && interior;
      if (acc) begin
        row_q  <= row_d;
        col_q  <= col_d;
        slot_q <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f1_row_q   <= cr;
      f1_col_q   <= c_cur;
      f1_pix_q   <= PIX_W'(pix);
      f1_done_q  <= done;
      f1_kzero_q <= (k_eff == '0);
    end
  end

  csmb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram_vert (
    .clk_i     (clk_i),
    .we_i      (acc),
    .waddr_i   (waddr),
    .wdata_i   (pix),
    .raddr_a_i (up_addr),
    .raddr_b_i (ctr_addr),
    .rdata_a_o (rd_up),
    .rdata_b_o (rd_ctr)
  );

  csmb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram_horz (
    .clk_i     (clk_i),
    .we_i      (acc),
    .waddr_i   (waddr),
    .wdata_i   (pix),
    .raddr_a_i (lft_addr),
    .raddr_b_i (rgt_addr),
    .rdata_a_o (rd_lft),
    .rdata_b_o (rd_rgt)
  );

  assign push_o.valid       = f1_valid_q;
  assign push_o.entry.row   = f1_row_q;
  assign push_o.entry.col   = f1_col_q;
  assign push_o.entry.pix   = f1_pix_q;
  assign push_o.entry.up    = PIX_W'(rd_up);
  assign push_o.entry.ctr   = PIX_W'(rd_ctr);
  assign push_o.entry.lft   = PIX_W'(rd_lft);
  assign push_o.entry.rgt   = PIX_W'(rd_rgt);
  assign push_o.entry.done  = f1_done_q;
  assign push_o.entry.kzero = f1_kzero_q;

  a_push_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_valid_q |-> $past(in_valid_i && !in_stall_o))
    else $error("push without an accepted pixel");

endmodule

// File: hdl/csmb_back.sv
module csmb_back import csmb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic              s1_valid_q;
  logic [SUM_W-1:0]  s1_sum_q;
  out_word_t         s1_meta_q;
  logic              s2_valid_q;
  logic [PROD_W-1:0] s2_prod_q;
  out_word_t         s2_meta_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  logic              s1_ready, s2_ready, s3_ready;
  logic [SUM_W-1:0]  sum_d;
  logic [PROD_W-1:0] quo_x;
  out_word_t         meta_d;
  out_word_t         out_d;

  assign s3_ready = !out_valid_q || !out_stall_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o    = head_i.valid && s1_ready;

  always_comb begin
    if (head_i.entry.kzero) begin
      sum_d = (SUM_W'(head_i.entry.pix) << 2) + SUM_W'(head_i.entry.pix);
    end else begin
      sum_d = SUM_W'(head_i.entry.pix) + SUM_W'(head_i.entry.up)
            + SUM_W'(head_i.entry.ctr) + SUM_W'(head_i.entry.lft)
            + SUM_W'(head_i.entry.rgt);
    end
    meta_d.out_row    = head_i.entry.row;
    meta_d.out_col    = head_i.entry.col;
    meta_d.blurred    = '0;
    meta_d.frame_done = head_i.entry.done;
    quo_x             = s2_prod_q >> DIV_SHIFT;
    out_d             = s2_meta_q;
    out_d.blurred     = quo_x[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= head_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_sum_q  <= sum_d;
      s1_meta_q <= meta_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_prod_q <= PROD_W'(s1_sum_q) * PROD_W'(RECIP5);
      s2_meta_q <= s1_meta_q;
    end
    if (s3_ready && s2_valid_q) begin
      out_word_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (quo_x[PROD_W-1:PIX_W] == '0))
    else $error("mean exceeds pixel range");

endmodule

// File: hdl/cross_stencil_mean_blur_core.sv
// Five-point cross mean over a raster pixel stream, one pixel accepted per clock while in_stall_o is low.
// A result is valid after the line-store read, queue, sum and reciprocal multiply by 1/5.
// Throughput: one pixel per cycle while in_stall_o is low; the two-read-port line stores serve all four neighbors.
// Reset: counters, config (1024 x 1024, reach 4) and pipeline valids clear; line store is not
// cleared and holds old frame data.
module cross_stencil_mean_blur_core import csmb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_REACH  = 8,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  push_t          push;
  q_head_t        head;
  logic           pop;
  logic [QLW-1:0] q_level;

  csmb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_REACH  (MAX_REACH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_level_i   (q_level),
    .push_o      (push)
  );

  csmb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (q_level)
  );

  csmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
